@@ rtl/julia_escape_time_pixel_core_assert.svh @@
// Assertion macros shared by the Julia escape-time pixel core.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef JULIA_ESCAPE_TIME_PIXEL_CORE_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define JETP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define JETP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/jetp_pkg.sv @@
// Package for the Julia escape-time pixel core: types, widths and register indexes.
// Has no dependencies; every other file of the core but the assertion header depends on it.
`timescale 1ns / 1ps

package jetp_pkg;

  localparam int COORD_W    = 10;
  localparam int ITER_W     = 10;
  localparam int COLOR_W    = 24;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PAN_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_COLOR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_COLOR = 3'd7;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic [ITER_W-1:0]         iter_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic signed [WORD_W-1:0]  word_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [13:0] pan_x;
    logic signed [13:0] pan_y;
    logic [30:0]        pixel_step;
    logic signed [30:0] c_real;
    logic signed [30:0] c_imag;
    iter_t              iter_limit;
    color_t             bound_color;
    color_t             escape_color;
  } cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    word_t  zr;
    word_t  zi;
  } map_item_t;

  typedef struct packed {
    logic      valid;
    map_item_t item;
  } q_push_t;

endpackage

@@ rtl/jetp_if.sv @@
// Channel interfaces of the Julia escape-time pixel core: pixel requests and results.
// Depends on jetp_pkg for the field widths.
`timescale 1ns / 1ps

interface jetp_pixel_if;
  logic                  valid;
  logic                  ready;
  jetp_pkg::coord_t      pixel_x;
  jetp_pkg::coord_t      pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface jetp_result_if;
  logic                  valid;
  logic                  ready;
  jetp_pkg::coord_t      out_x;
  jetp_pkg::coord_t      out_y;
  jetp_pkg::iter_t       iter_count;
  logic                  is_inside;
  jetp_pkg::color_t      pixel_color;

  modport source (output valid, output out_x, output out_y, output iter_count,
                  output is_inside, output pixel_color, input ready);
  modport sink   (input valid, input out_x, input out_y, input iter_count,
                  input is_inside, input pixel_color, output ready);
endinterface

@@ rtl/jetp_front.sv @@
// Front end: accepts pixel requests and maps them to complex start points.
// Depends on jetp_pkg and jetp_pixel_if; feeds jetp_queue.
`timescale 1ns / 1ps

module jetp_front #(
  parameter int FRAME_WIDTH  = 1024,
  parameter int FRAME_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  jetp_pixel_if.sink         in_pix,
  input  jetp_pkg::cfg_t     cfg,
  output jetp_pkg::q_push_t  push,
  input  logic               push_ready
);
  import jetp_pkg::*;

  localparam int SIZE_MAX = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int D2_W     = $clog2(SIZE_MAX + 2**15 + 2**11) + 1;
  localparam int PW       = D2_W + WORD_W;

  function automatic word_t sat_prod(input logic signed [PW-1:0] v);
    logic fits;
    fits = (&v[PW-1:WORD_W-1]) || !(|v[PW-1:WORD_W-1]);
    if (fits) return v[WORD_W-1:0];
    return v[PW-1] ? WORD_MIN : WORD_MAX;
  endfunction

  logic                   a_v_r, b_v_r;
  coord_t                 a_x_r, a_y_r, b_x_r, b_y_r;
  logic signed [D2_W-1:0] a_dx_r, a_dy_r, a_dx_nxt, a_dy_nxt;
  logic signed [PW-1:0]   b_px_r, b_py_r, b_px_nxt, b_py_nxt;
  logic signed [PW-1:0]   half_x, half_y;
  logic signed [WORD_W-1:0] step_s;
  logic                   a_adv, b_adv;

  assign b_adv        = !b_v_r || push_ready;
  assign a_adv        = !a_v_r || b_adv;
  assign in_pix.ready = a_adv;

  // Twice the centred coordinate, so the half-pixel offset stays exact.
  assign a_dx_nxt = {{(D2_W-COORD_W-1){1'b0}}, in_pix.pixel_x, 1'b0}
                  - D2_W'(FRAME_WIDTH)
                  + {{(D2_W-15){cfg.pan_x[13]}}, cfg.pan_x, 1'b0};
  assign a_dy_nxt = {{(D2_W-COORD_W-1){1'b0}}, in_pix.pixel_y, 1'b0}
                  - D2_W'(FRAME_HEIGHT)
                  + {{(D2_W-15){cfg.pan_y[13]}}, cfg.pan_y, 1'b0};

  assign step_s   = {1'b0, cfg.pixel_step};
  assign b_px_nxt = a_dx_r * step_s;
  assign b_py_nxt = a_dy_r * step_s;

  assign half_x = b_px_r >>> 1;
  assign half_y = b_py_r >>> 1;

  assign push.valid   = b_v_r;
  assign push.item.x  = b_x_r;
  assign push.item.y  = b_y_r;
  assign push.item.zr = sat_prod(half_x);
  assign push.item.zi = sat_prod(half_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= in_pix.valid;
      if (b_adv) b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_pix.valid) begin
      a_x_r  <= in_pix.pixel_x;
      a_y_r  <= in_pix.pixel_y;
      a_dx_r <= a_dx_nxt;
      a_dy_r <= a_dy_nxt;
    end
    if (b_adv && a_v_r) begin
      b_x_r  <= a_x_r;
      b_y_r  <= a_y_r;
      b_px_r <= b_px_nxt;
      b_py_r <= b_py_nxt;
    end
  end

endmodule

@@ rtl/jetp_queue.sv @@
// Short queue of mapped start points between the front end and the iteration engine.
// Depends on jetp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_core_assert.svh"

module jetp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jetp_pkg::q_push_t    push,
  output logic                 push_ready,
  output logic                 pop_valid,
  output jetp_pkg::map_item_t  pop_item,
  input  logic                 pop_ready
);
  import jetp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  map_item_t        entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push_fire  = push.valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push_fire && !pop_fire) count_nxt = CNT_W'(count_r + 1'b1);
    if (pop_fire && !push_fire) count_nxt = CNT_W'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) entry_r[wr_ptr_r] <= push.item;
  end

  `JETP_ASSERT_NEXT(a_q_count_up, push_fire && !pop_fire,
                    count_r == CNT_W'($past(count_r) + 1'b1),
                    "queue fill level did not rise after a lone push")
  `JETP_ASSERT_NEXT(a_q_count_hold, push_fire && pop_fire,
                    count_r == $past(count_r),
                    "queue fill level changed on a simultaneous push and pop")

endmodule

@@ rtl/jetp_back.sv @@
// Iteration engine: runs z = z^2 + c on one start point and registers the result.
// Depends on jetp_pkg, jetp_result_if and the assertion macro header.
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_core_assert.svh"

module jetp_back #(
  parameter int FRAC_BITS = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jetp_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  jetp_pkg::map_item_t  q_item,
  output logic                 q_ready,
  jetp_result_if.source        out_res
);
  import jetp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_TEST = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [63:0] LIMIT = 64'd4 << (2 * FRAC_BITS);

  function automatic word_t sat66(input logic signed [65:0] v);
    logic fits;
    fits = (&v[65:WORD_W-1]) || !(|v[65:WORD_W-1]);
    if (fits) return v[WORD_W-1:0];
    return v[65] ? WORD_MIN : WORD_MAX;
  endfunction

  logic [1:0]          state_r, state_nxt;
  coord_t              x_r, y_r, x_nxt, y_nxt;
  word_t               zr_r, zi_r, zr_nxt, zi_nxt;
  iter_t               n_r, n_nxt;
  logic signed [63:0]  xx_r, yy_r, xy_r, xx_nxt, yy_nxt, xy_nxt;
  logic                out_v_r, out_v_nxt;
  coord_t              out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  iter_t               out_n_r, out_n_nxt;
  logic                out_in_r, out_in_nxt;
  color_t              out_c_r, out_c_nxt;
  logic [63:0]         mag2;
  logic signed [65:0]  cr_sh, ci_sh, tr, ti, tr_sh, ti_sh;
  logic                escaped, finish, out_free, at_limit;

  assign mag2     = {1'b0, xx_r[62:0]} + {1'b0, yy_r[62:0]};
  assign escaped  = (mag2 > LIMIT);
  assign finish   = escaped || (n_r >= cfg.iter_limit);
  assign at_limit = (n_r == cfg.iter_limit);

  // Adding c ahead of the shift keeps the floor rounding exact.
  assign cr_sh = {{35{cfg.c_real[30]}}, cfg.c_real} << FRAC_BITS;
  assign ci_sh = {{35{cfg.c_imag[30]}}, cfg.c_imag} << (FRAC_BITS - 1);
  assign tr    = {{2{xx_r[63]}}, xx_r} - {{2{yy_r[63]}}, yy_r} + cr_sh;
  assign ti    = {{2{xy_r[63]}}, xy_r} + ci_sh;
  assign tr_sh = tr >>> FRAC_BITS;
  assign ti_sh = ti >>> (FRAC_BITS - 1);

  assign out_free = !out_v_r || out_res.ready;

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    zr_nxt     = zr_r;
    zi_nxt     = zi_r;
    n_nxt      = n_r;
    xx_nxt     = xx_r;
    yy_nxt     = yy_r;
    xy_nxt     = xy_r;
    q_ready    = 1'b0;
    out_v_nxt  = out_v_r && !out_res.ready;
    out_x_nxt  = out_x_r;
    out_y_nxt  = out_y_r;
    out_n_nxt  = out_n_r;
    out_in_nxt = out_in_r;
    out_c_nxt  = out_c_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_ready   = 1'b1;
          x_nxt     = q_item.x;
          y_nxt     = q_item.y;
          zr_nxt    = q_item.zr;
          zi_nxt    = q_item.zi;
          n_nxt     = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        xx_nxt    = zr_r * zr_r;
        yy_nxt    = zi_r * zi_r;
        xy_nxt    = zr_r * zi_r;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (finish) begin
          state_nxt = ST_DONE;
          if (out_free) state_nxt = ST_IDLE;
        end else begin
          zr_nxt    = sat66(tr_sh);
          zi_nxt    = sat66(ti_sh);
          n_nxt     = ITER_W'(n_r + 1'b1);
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (((state_r == ST_TEST) && finish || (state_r == ST_DONE)) && out_free) begin
      out_v_nxt  = 1'b1;
      out_x_nxt  = x_r;
      out_y_nxt  = y_r;
      out_n_nxt  = n_r;
      out_in_nxt = at_limit;
      out_c_nxt  = at_limit ? cfg.bound_color : cfg.escape_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    zr_r     <= zr_nxt;
    zi_r     <= zi_nxt;
    n_r      <= n_nxt;
    xx_r     <= xx_nxt;
    yy_r     <= yy_nxt;
    xy_r     <= xy_nxt;
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_n_r  <= out_n_nxt;
    out_in_r <= out_in_nxt;
    out_c_r  <= out_c_nxt;
  end

  assign out_res.valid       = out_v_r;
  assign out_res.out_x       = out_x_r;
  assign out_res.out_y       = out_y_r;
  assign out_res.iter_count  = out_n_r;
  assign out_res.is_inside   = out_in_r;
  assign out_res.pixel_color = out_c_r;

  `JETP_ASSERT_NEXT(a_pop_starts_mul, q_valid && q_ready, state_r == ST_MUL,
                    "a popped start point did not enter the product stage")
  `JETP_ASSERT_NEXT(a_iter_step, (state_r == ST_TEST) && !finish,
                    (state_r == ST_MUL) && (n_r == ITER_W'($past(n_r) + 1'b1)),
                    "an unfinished iteration did not advance the count")

endmodule

@@ rtl/julia_escape_time_pixel_core.sv @@
// Top level of the Julia escape-time pixel core: configuration registers and wiring.
// Depends on jetp_pkg, jetp_if, jetp_front, jetp_queue and jetp_back.
//
// Usage: pixel requests (pixel_x, pixel_y) enter on in_pix; one result per request
// leaves on out_res in request order, carrying the echoed pixel, the iteration count,
// the inside flag and the chosen colour. A request is taken when valid and ready are
// both high. Registers are written through cfg_we, cfg_index and cfg_wdata while the
// core is idle; unknown indexes cannot occur with the three-bit index.
// The single iteration engine holds one pixel at a time: it pops a start point,
// then per iteration forms the products in its three 32 by 32 multipliers and
// next runs the escape test, ending the pixel or updating z. The mapping front end
// and a two-entry queue run ahead, so requests are taken while the engine is busy.
// A stalled receiver holds the result register; the engine finishes its current
// pixel and waits, the queue fills and in_pix.ready then falls.
// Reset clears the pipeline, the queue and the output valid, and loads the default
// register values; it needs no clearing pass.
`timescale 1ns / 1ps

module julia_escape_time_pixel_core #(
  parameter int FRAME_WIDTH  = 1024,
  parameter int FRAME_HEIGHT = 1024,
  parameter int FRAC_BITS    = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  jetp_pixel_if.sink                          in_pix,
  jetp_result_if.source                       out_res,
  input  logic                                cfg_we,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jetp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import jetp_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  q_push_t   push;
  logic      push_ready;
  logic      q_valid, q_ready;
  map_item_t q_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PAN_X:        cfg_nxt.pan_x        = cfg_wdata[13:0];
        REG_PAN_Y:        cfg_nxt.pan_y        = cfg_wdata[13:0];
        REG_PIXEL_STEP:   cfg_nxt.pixel_step   = cfg_wdata[30:0];
        REG_C_REAL:       cfg_nxt.c_real       = cfg_wdata[30:0];
        REG_C_IMAG:       cfg_nxt.c_imag       = cfg_wdata[30:0];
        REG_ITER_LIMIT:   cfg_nxt.iter_limit   = cfg_wdata[ITER_W-1:0];
        REG_BOUND_COLOR:  cfg_nxt.bound_color  = cfg_wdata[COLOR_W-1:0];
        REG_ESCAPE_COLOR: cfg_nxt.escape_color = cfg_wdata[COLOR_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pan_x        <= 14'sd0;
      cfg_r.pan_y        <= 14'sd0;
      cfg_r.pixel_step   <= 31'd1048576;
      cfg_r.c_real       <= 31'sd85362475;
      cfg_r.c_imag       <= 31'sd23890756;
      cfg_r.iter_limit   <= 10'd100;
      cfg_r.bound_color  <= 24'h000000;
      cfg_r.escape_color <= 24'hFFFFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jetp_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pix     (in_pix),
    .cfg        (cfg_r),
    .push       (push),
    .push_ready (push_ready)
  );

  jetp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_ready)
  );

  jetp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .out_res (out_res)
  );

endmodule
